// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int VALUE_W  = 32;
   localparam int PRIO_W   = 16;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  prio;
   } entry_type;

   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type item;
   } cell_ctrl_type;

endpackage

// ===== src/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels for queue operations and their results.
// ----------------------------------------------------------------------------
interface spq_req_if
   import spq_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [VALUE_W-1:0] item_value;
   logic signed [PRIO_W-1:0]  item_priority;

   modport source (output valid, output mode, output item_value, output item_priority,
                   input ready);
   modport sink   (input valid, input mode, input item_value, input item_priority,
                   output ready);
endinterface

interface spq_rsp_if
   import spq_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] head_value;
   logic [STATUS_W-1:0]       status;
   logic [FILL_W-1:0]         fill_count;

   modport source (output valid, output head_value, output status, output fill_count,
                   input ready);
   modport sink   (input valid, input head_value, input status, input fill_count,
                   output ready);
endinterface

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: compares, shifts right on insert, left on remove.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  entry_type     left_entry,
   input  logic          left_ins,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          ins
);

   entry_type entry_ff;
   entry_type entry_in;

   // new item lands at or ahead of this slot (ahead of equal priorities)
   assign ins = !occupied || (ctrl.item.prio >= entry_ff.prio);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.enq && ins) begin
         entry_in = left_ins ? left_entry : ctrl.item;
      end else if (ctrl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== src/sorted_priority_queue.sv =====
// Result: head, status and fill are registered when the item is accepted.
// Throughput: one item per cycle while no result is held or the held one is taken;
// every slot compares and shifts in parallel across the row of cells.
// Reset: count and result valid cleared; slot contents stay undefined until
// written and are never read before then.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Fixed-capacity priority queue held as a row of sorted cells, head at cell 0.
// ----------------------------------------------------------------------------
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16
)(
   input  logic clock,
   input  logic reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff;
   logic signed [VALUE_W-1:0] head_ff, head_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic [FILL_W-1:0]         fill_ff;

   logic          accept, full, empty;
   cell_ctrl_type ctrl;
   entry_type     cell_entry [CAPACITY];
   logic          cell_ins   [CAPACITY];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == CNT_W'(CAPACITY));
   assign empty        = (count_ff == '0);

   assign ctrl.enq        = accept && (req_ch.mode == MODE_ENQ) && !full;
   assign ctrl.deq        = accept && (req_ch.mode == MODE_DEQ) && !empty;
   assign ctrl.item.value = req_ch.item_value;
   assign ctrl.item.prio  = req_ch.item_priority;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_i;
      if (i == 0) begin : g_first
         assign left_e = cell_entry[0];
         assign left_i = 1'b0;
      end else begin : g_mid
         assign left_e = cell_entry[i-1];
         assign left_i = cell_ins[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_e = cell_entry[i];
      end else begin : g_body
         assign right_e = cell_entry[i+1];
      end
      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (CNT_W'(i) < count_ff),
         .left_entry  (left_e),
         .left_ins    (left_i),
         .right_entry (right_e),
         .entry       (cell_entry[i]),
         .ins         (cell_ins[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      head_in   = '0;
      status_in = STATUS_OK;
      case (req_ch.mode)
         MODE_ENQ: begin
            if (full) status_in = STATUS_FULL;
            else      count_in  = count_ff + CNT_W'(1);
         end
         MODE_DEQ, MODE_PEEK: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               head_in = cell_entry[0].value;
               if (req_ch.mode == MODE_DEQ) count_in = count_ff - CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         head_ff   <= head_in;
         status_ff <= status_in;
         fill_ff   <= FILL_W'(count_in);
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.head_value = head_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.fill_count = fill_ff;

endmodule

// ===== src/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue.
// ----------------------------------------------------------------------------
module spq_checker
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16
)(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] head_value,
   input logic [STATUS_W-1:0]       status,
   input logic [FILL_W-1:0]         fill_count
);

   a_accept_gives_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(head_value) && $stable(status)
                                  && $stable(fill_count))
      else $error("stalled result changed");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_EMPTY |-> head_value == '0 && fill_count == '0)
      else $error("empty result carries data or count");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_FULL |-> head_value == '0
                                           && fill_count == FILL_W'(CAPACITY))
      else $error("full result wrong");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .head_value (rsp_ch.head_value),
   .status     (rsp_ch.status),
   .fill_count (rsp_ch.fill_count)
);

// ===== tb/sorted_priority_queue_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// Drives enqueue, dequeue, peek and unused-mode items into the queue with
// random gaps and result back-pressure. A shadow sorted row predicts each
// result, which is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
   import spq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 26;
   localparam int GAP_PCT     = 14;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic signed [VALUE_W-1:0] head;
      logic [STATUS_W-1:0]       status;
      logic [FILL_W-1:0]         fill;
   } queue_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;
   int   mismatches = 0;
   int   cycle_count = 0;

   entry_type        shadow_row [DEPTH];
   int               shadow_count = 0;
   queue_result_type awaited_results [$];

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   sorted_priority_queue #(.CAPACITY(DEPTH)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the sorted row; new entries go ahead of equal priorities
   function automatic queue_result_type predict_queue_op(logic [MODE_W-1:0] mode,
                                                         logic signed [VALUE_W-1:0] value,
                                                         logic signed [PRIO_W-1:0] prio);
      queue_result_type r;
      int pos;
      r.head   = '0;
      r.status = STATUS_OK;
      case (mode)
         MODE_ENQ: begin
            if (shadow_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < shadow_count && $signed(prio) < $signed(shadow_row[pos].prio))
                  pos++;
               for (int i = shadow_count; i > pos; i--)
                  shadow_row[i] = shadow_row[i-1];
               shadow_row[pos].value = value;
               shadow_row[pos].prio  = prio;
               shadow_count++;
            end
         end
         MODE_DEQ, MODE_PEEK: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.head = shadow_row[0].value;
               if (mode == MODE_DEQ) begin
                  for (int i = 0; i + 1 < shadow_count; i++)
                     shadow_row[i] = shadow_row[i+1];
                  shadow_count--;
               end
            end
         end
         default: ;
      endcase
      r.fill = FILL_W'(shadow_count);
      return r;
   endfunction

   task automatic send_op(input logic [MODE_W-1:0] mode,
                          input logic signed [VALUE_W-1:0] value,
                          input logic signed [PRIO_W-1:0] prio);
      int gap;
      if (!quiet && $urandom_range(99) < GAP_PCT) begin
         gap = $urandom_range(1, 4);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.mode          <= mode;
      req_ch.item_value    <= value;
      req_ch.item_priority <= prio;
      do @(posedge clock); while (!req_ch.ready);
      awaited_results.push_back(predict_queue_op(mode, value, prio));
   endtask

   task automatic test_empty_queue();
      send_op(MODE_DEQ, 32'sh1234_5678, 16'sd7);
      send_op(MODE_PEEK, -32'sd1, -16'sd1);
      send_op(MODE_UNUSED, 32'sh7fff_ffff, 16'sh7fff);
   endtask

   task automatic test_fill_to_capacity();
      logic signed [PRIO_W-1:0] prio_set [DEPTH] = '{
         16'sh7fff, -16'sh8000, 16'sd0, -16'sd1, 16'sd1, 16'sd5, 16'sd5, 16'sd5,
         -16'sd1, 16'sh7fff, 16'sd0, -16'sh8000, 16'sd5, 16'sd2, 16'sh7ffe, -16'sd2};
      logic signed [VALUE_W-1:0] value;
      for (int i = 0; i < DEPTH; i++) begin
         case (i)
            0:       value = 32'sh7fff_ffff;
            1:       value = 32'sh8000_0000;
            2:       value = 32'sd0;
            3:       value = -32'sd1;
            default: value = $urandom;
         endcase
         send_op(MODE_ENQ, value, prio_set[i]);
      end
      send_op(MODE_ENQ, 32'sh5555_aaaa, 16'sh7fff);
      send_op(MODE_UNUSED, 32'sd0, 16'sd0);
      send_op(MODE_PEEK, 32'sd0, 16'sd0);
      repeat (3) send_op(MODE_DEQ, $urandom, PRIO_W'($urandom));
   endtask

   function automatic logic [MODE_W-1:0] pick_mode(int enq_pct);
      int r;
      r = $urandom_range(99);
      if (r < 3)
         return MODE_UNUSED;
      if (r < 3 + enq_pct * 97 / 100)
         return MODE_ENQ;
      return ($urandom_range(9) < 7) ? MODE_DEQ : MODE_PEEK;
   endfunction

   function automatic logic signed [PRIO_W-1:0] pick_priority();
      case ($urandom_range(7))
         0, 1:    return PRIO_W'($signed($urandom_range(4)) - 2);
         2:       return $urandom_range(1) ? 16'sh7fff : -16'sh8000;
         default: return PRIO_W'($urandom);
      endcase
   endfunction

   // bursts of mostly enqueues, mostly dequeues and mixed traffic
   task automatic test_random_bursts();
      int enq_pct;
      for (int phase = 0; phase < 17; phase++) begin
         case (phase % 3)
            0:       enq_pct = 85;
            1:       enq_pct = 20;
            default: enq_pct = 50;
         endcase
         quiet = (phase >= 6 && phase <= 8);
         for (int n = 0; n < 50; n++)
            send_op(pick_mode(enq_pct), $urandom, pick_priority());
      end
      quiet = 1'b0;
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= quiet || $urandom_range(99) >= IDLE_PCT;
      end
   end

   initial begin
      queue_result_type exp_r;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               if (mismatches < 10)
                  $display("ERROR: unexpected result head=%0d status=%0d fill=%0d",
                           rsp_ch.head_value, rsp_ch.status, rsp_ch.fill_count);
               mismatches++;
            end else begin
               exp_r = awaited_results.pop_front();
               if (rsp_ch.head_value !== exp_r.head || rsp_ch.status !== exp_r.status ||
                   rsp_ch.fill_count !== exp_r.fill) begin
                  if (mismatches < 10)
                     $display("ERROR: expected head=%0d status=%0d fill=%0d, got %0d %0d %0d",
                              exp_r.head, exp_r.status, exp_r.fill, rsp_ch.head_value,
                              rsp_ch.status, rsp_ch.fill_count);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sorted_priority_queue test failed");
      $finish;
   end

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.mode          = MODE_ENQ;
      req_ch.item_value    = '0;
      req_ch.item_priority = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_fill_to_capacity();
      test_random_bursts();
      req_ch.valid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0)
         $display("sorted_priority_queue test passed");
      else
         $display("sorted_priority_queue test failed");
      $finish;
   end

endmodule
